>>> design/bdy_pkg.sv
`default_nettype none

package bdy_pkg;

	typedef enum logic [1:0] {
		ST_ABSENT = 2'd0,
		ST_FREE   = 2'd1,
		ST_USED   = 2'd2,
		ST_SPLIT  = 2'd3
	} node_st_t;

	localparam int NODE_STW = 2;

	typedef struct packed {
		logic        status;
		logic [10:0] granted_index;
		logic [10:0] block_kb;
		logic [10:0] free_kb;
	} res_t;

endpackage

`default_nettype wire

>>> design/bdy_ram.sv
`default_nettype none

module bdy_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> design/bdy_engine.sv
`default_nettype none

module bdy_engine #(
	parameter int MAX_LOG2 = 10
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [$clog2(MAX_LOG2+1)-1:0]       t,
	input  wire logic                                clr,
	input  wire logic [$clog2(MAX_LOG2+1)-1:0]       t_new,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                mode,
	input  wire logic [10:0]                         request_kb,
	input  wire logic [10:0]                         node_index,
	output logic                                     res_valid,
	input  wire logic                                res_ready,
	output bdy_pkg::res_t                            res,
	output logic                                     ram_we,
	output logic      [MAX_LOG2:0]                   ram_waddr,
	output logic      [bdy_pkg::NODE_STW-1:0]        ram_wdata,
	output logic                                     ram_re,
	output logic      [MAX_LOG2:0]                   ram_raddr,
	input  wire logic [bdy_pkg::NODE_STW-1:0]        ram_rdata
);
	import bdy_pkg::*;

	localparam int IW = MAX_LOG2 + 1;
	localparam int LW = $clog2(MAX_LOG2 + 1);
	localparam int FW = MAX_LOG2 + 1;
	localparam int CW = (MAX_LOG2 + 2 > 12) ? MAX_LOG2 + 2 : 12;
	localparam int RST_T = (10 > MAX_LOG2) ? MAX_LOG2 : 10;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, A_RD, A_EV, A_UP, A_SPL_L, A_SPL_R,
		F_RD, F_EV, F_BRD, F_BEV, F_M1, F_M2, S_DONE
	} state_t;

	state_t         state_q;
	logic [IW-1:0]  cur_q;
	logic [LW-1:0]  dep_q;
	logic [10:0]    req_q;
	logic           mode_q;
	logic [FW-1:0]  free_q;
	logic [CW-1:0]  blk_q;
	logic           status_q;
	logic [IW-1:0]  granted_q;
	logic [IW-1:0]  cnt_q;

	node_st_t       rd_st;
	logic [CW-1:0]  size_c;
	logic [CW-1:0]  req_c;
	logic [CW-1:0]  nidx_c;
	logic [LW-1:0]  nidx_dep;
	logic           req_ok;
	logic           nidx_ok;
	logic           fits;
	logic [IW-1:0]  left_c;
	logic [IW-1:0]  parent_c;
	logic [CW-1:0]  g_ext;
	logic [CW-1:0]  f_ext;

	assign rd_st   = node_st_t'(ram_rdata);
	assign size_c  = CW'(1) << (t - dep_q);
	assign req_c   = CW'(req_q);
	assign nidx_c  = CW'(node_index);
	assign req_ok  = (request_kb != '0) && (CW'(request_kb) <= (CW'(1) << t));
	assign nidx_ok = (node_index != '0) && (nidx_c < (CW'(2) << t));
	assign fits    = (size_c == req_c) || ((size_c >> 1) < req_c);
	assign left_c  = {cur_q[IW-2:0], 1'b0};
	assign parent_c = cur_q >> 1;

	// depth of a heap index is the position of its leading one
	always_comb begin
		nidx_dep = '0;
		for (int i = 1; i < IW; i++) begin
			if (nidx_c[i]) nidx_dep = LW'(i);
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_q;
		ram_wdata = ST_ABSENT;
		ram_re    = 1'b0;
		ram_raddr = cur_q;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q;
				ram_wdata = (cnt_q == IW'(1)) ? ST_FREE : ST_ABSENT;
			end
			A_RD, F_RD: ram_re = 1'b1;
			F_BRD: begin
				ram_re    = 1'b1;
				ram_raddr = cur_q ^ IW'(1);
			end
			A_EV: begin
				if (!(size_c < req_c) && rd_st == ST_FREE) begin
					ram_we    = 1'b1;
					ram_wdata = fits ? ST_USED : ST_SPLIT;
				end
			end
			A_SPL_L: begin
				ram_we    = 1'b1;
				ram_waddr = left_c;
				ram_wdata = ST_FREE;
			end
			A_SPL_R: begin
				ram_we    = 1'b1;
				ram_waddr = left_c | IW'(1);
				ram_wdata = ST_FREE;
			end
			F_EV: begin
				ram_we    = (rd_st == ST_USED);
				ram_wdata = ST_FREE;
			end
			F_BEV: begin
				ram_we    = (rd_st == ST_FREE);
				ram_waddr = parent_c;
				ram_wdata = ST_FREE;
			end
			F_M1: begin
				ram_we    = 1'b1;
				ram_waddr = {cur_q[IW-1:1], 1'b0};
			end
			F_M2: begin
				ram_we    = 1'b1;
				ram_waddr = {cur_q[IW-1:1], 1'b1};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			cnt_q     <= '0;
			free_q    <= FW'(1) << RST_T;
			cur_q     <= '0;
			dep_q     <= '0;
			req_q     <= '0;
			mode_q    <= 1'b0;
			blk_q     <= '0;
			status_q  <= 1'b1;
			granted_q <= '0;
		end else if (clr) begin
			state_q <= S_CLEAR;
			cnt_q   <= '0;
			free_q  <= FW'(1) << t_new;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					cnt_q <= cnt_q + IW'(1);
					if (cnt_q == '1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						mode_q    <= mode;
						req_q     <= request_kb;
						status_q  <= 1'b1;
						granted_q <= '0;
						blk_q     <= '0;
						if (!mode) begin
							cur_q   <= IW'(1);
							dep_q   <= '0;
							state_q <= req_ok ? A_RD : S_DONE;
						end else begin
							cur_q   <= IW'(node_index);
							dep_q   <= nidx_dep;
							state_q <= nidx_ok ? F_RD : S_DONE;
						end
					end
				end
				A_RD: state_q <= A_EV;
				A_EV: begin
					if (size_c < req_c) begin
						state_q <= A_UP;
					end else begin
						unique case (rd_st)
							ST_FREE: begin
								if (fits) begin
									status_q  <= 1'b0;
									granted_q <= cur_q;
									blk_q     <= size_c;
									free_q    <= free_q - FW'(size_c);
									state_q   <= S_DONE;
								end else begin
									state_q <= A_SPL_L;
								end
							end
							ST_SPLIT: begin
								cur_q   <= left_c;
								dep_q   <= dep_q + LW'(1);
								state_q <= A_RD;
							end
							ST_ABSENT, ST_USED: state_q <= A_UP;
						endcase
					end
				end
				// backtrack: right sibling next, or climb past a finished subtree
				A_UP: begin
					if (cur_q == IW'(1)) begin
						state_q <= S_DONE;
					end else if (!cur_q[0]) begin
						cur_q   <= cur_q | IW'(1);
						state_q <= A_RD;
					end else begin
						cur_q <= parent_c;
						dep_q <= dep_q - LW'(1);
					end
				end
				A_SPL_L: state_q <= A_SPL_R;
				A_SPL_R: begin
					cur_q   <= left_c;
					dep_q   <= dep_q + LW'(1);
					state_q <= A_RD;
				end
				F_RD: state_q <= F_EV;
				F_EV: begin
					if (rd_st == ST_USED) begin
						status_q <= 1'b0;
						blk_q    <= size_c;
						free_q   <= free_q + FW'(size_c);
						state_q  <= (cur_q == IW'(1)) ? S_DONE : F_BRD;
					end else begin
						state_q <= S_DONE;
					end
				end
				F_BRD: state_q <= F_BEV;
				F_BEV: state_q <= (rd_st == ST_FREE) ? F_M1 : S_DONE;
				F_M1: state_q <= F_M2;
				F_M2: begin
					cur_q   <= parent_c;
					state_q <= (parent_c == IW'(1)) ? S_DONE : F_BRD;
				end
				S_DONE: begin
					if (res_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign g_ext     = CW'(granted_q);
	assign f_ext     = CW'(free_q);

	always_comb begin
		res.status        = status_q;
		res.granted_index = g_ext[10:0];
		res.block_kb      = blk_q[10:0];
		res.free_kb       = f_ext[10:0];
	end

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		f_ext <= (CW'(1) << t))
		else $error("free count exceeds managed size");

	a_grant_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !status_q && !mode_q |-> granted_q != '0)
		else $error("successful allocate without a node");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status_q |-> granted_q == '0 && blk_q == '0)
		else $error("refused item carries a block");

endmodule

`default_nettype wire

>>> design/buddy_allocator_unit.sv
// Binary buddy allocator over 2^t_q KB, tree held in a node-state RAM.
// Input channel (in_valid/in_ready): mode 0 allocates request_kb, mode 1
// frees the block at heap index node_index. One result per item on the
// output channel (out_valid/out_ready): status, granted_index, block_kb and
// the free KB left.
// An item is read and evaluated node by node: each node visited is read and
// then evaluated, backtracking climbs or steps to the right sibling, and a
// split writes both children free before descending. A free marks the node
// free, then merges with its buddy level by level while the buddy is free.
// One item is in work at a time; the next is taken once the result moves
// into the output register.
// Reset and every write of cfg_wdata (cfg_we high) sweep all 2^(MAX_LOG2+1)
// node RAM entries (2048 by default), one entry a cycle; no item is accepted
// meanwhile. Sizes above MAX_LOG2 saturate.
// When the receiver stalls, the result holds in the output register and the
// engine can finish one more item, which then waits until out_ready.
`default_nettype none

module buddy_allocator_unit #(
	parameter int MAX_LOG2 = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        mode,
	input  wire logic [10:0] request_kb,
	input  wire logic [10:0] node_index,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             status,
	output logic      [10:0] granted_index,
	output logic      [10:0] block_kb,
	output logic      [10:0] free_kb,
	input  wire logic        cfg_we,
	input  wire logic [3:0]  cfg_wdata
);
	import bdy_pkg::*;

	localparam int IW = MAX_LOG2 + 1;
	localparam int LW = $clog2(MAX_LOG2 + 1);
	localparam int RST_T = (10 > MAX_LOG2) ? MAX_LOG2 : 10;

	logic [LW-1:0]       t_q;
	logic [LW-1:0]       t_new;
	logic                res_valid;
	logic                res_ready;
	res_t                res;
	res_t                res_q;
	logic                out_valid_q;
	logic                ram_we;
	logic [IW-1:0]       ram_waddr;
	logic [NODE_STW-1:0] ram_wdata;
	logic                ram_re;
	logic [IW-1:0]       ram_raddr;
	logic [NODE_STW-1:0] ram_rdata;

	assign t_new = (int'(cfg_wdata) > MAX_LOG2) ? LW'(MAX_LOG2) : LW'(cfg_wdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q <= LW'(RST_T);
		end else if (cfg_we) begin
			t_q <= t_new;
		end
	end

	bdy_ram #(
		.WIDTH(NODE_STW),
		.DEPTH(2 ** IW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	bdy_engine #(
		.MAX_LOG2(MAX_LOG2)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.t         (t_q),
		.clr       (cfg_we),
		.t_new     (t_new),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.request_kb(request_kb),
		.node_index(node_index),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// output register frees the engine as soon as a result is handed over
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = res_q.status;
	assign granted_index = res_q.granted_index;
	assign block_kb      = res_q.block_kb;
	assign free_kb       = res_q.free_kb;

	a_size_sat: assert property (@(posedge clk) disable iff (!arst_n)
		int'(t_q) <= MAX_LOG2)
		else $error("size register above maximum");

	a_handover: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |=> out_valid_q)
		else $error("result lost on transfer into output register");

endmodule

`default_nettype wire
